@@ hdl/swpg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swpg_pkg;

  localparam int unsigned CIRC_W     = 12;
  localparam int unsigned PPR_W      = 7;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned HP_W       = 24;
  localparam int unsigned PROD_W     = SPEED_W + PPR_W;
  localparam int unsigned SCALE_W    = 17;
  localparam int unsigned DVD_W      = CIRC_W + SCALE_W;
  localparam int unsigned SLOW_W     = PROD_W + 10;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [SCALE_W-1:0] HalfPeriodScale = SCALE_W'(128000);
  localparam logic [9:0]         SlowScale       = 10'd625;
  localparam logic [CIRC_W-1:0]  CircReset       = CIRC_W'(1850);
  localparam logic [PPR_W-1:0]   PprReset        = PPR_W'(1);
  localparam logic [HP_W-1:0]    HalfPeriodMax   = {HP_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DivLastBit    = DIV_CNT_W'(DVD_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRC = 1'b0,
    REG_PPR  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic accept;
    logic check;
    logic step;
    logic finish;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic slow;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/swpg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface swpg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [swpg_pkg::SPEED_W-1:0]  speed_q8;
  logic                          has_fix;

  modport source (output valid, output action, output speed_q8, output has_fix, input ready);
  modport sink (input valid, input action, input speed_q8, input has_fix, output ready);
endinterface

interface swpg_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pulse_out;
  logic                       pulse_enabled;
  logic [swpg_pkg::HP_W-1:0]  half_cycle_us;

  modport source (output valid, output pulse_out, output pulse_enabled,
                  output half_cycle_us, input ready);
  modport sink (input valid, input pulse_out, input pulse_enabled,
                input half_cycle_us, output ready);
endinterface

`default_nettype wire

@@ hdl/swpg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swpg_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire swpg_pkg::dp_status_t  status_i,
  output swpg_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.is_tick ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.slow ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/swpg_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swpg_dpath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire swpg_pkg::ctrl_cmd_t                    cmd_i,
  output swpg_pkg::dp_status_t                        status_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [swpg_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [swpg_pkg::CIRC_W-1:0]            cfg_data_i,
  input  wire logic                                   in_action_i,
  input  wire logic [swpg_pkg::SPEED_W-1:0]           in_speed_q8_i,
  input  wire logic                                   in_has_fix_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        out_pulse_out_o,
  output logic                                        out_pulse_enabled_o,
  output logic [swpg_pkg::HP_W-1:0]                   out_half_cycle_us_o
);

  logic [swpg_pkg::CIRC_W-1:0]    circ_q;
  logic [swpg_pkg::PPR_W-1:0]     ppr_q;

  logic                           level_q;
  logic                           running_q;
  logic [swpg_pkg::HP_W-1:0]      half_period_q;
  logic [swpg_pkg::HP_W-1:0]      tick_q;

  logic                           fix_q;
  logic [swpg_pkg::PROD_W-1:0]    prod_q;
  logic [swpg_pkg::PROD_W-1:0]    rem_q;
  logic [swpg_pkg::DVD_W-1:0]     quot_q;
  logic [swpg_pkg::DIV_CNT_W-1:0] cnt_q;

  logic                           out_valid_q;
  logic                           out_level_q;
  logic                           out_running_q;
  logic [swpg_pkg::HP_W-1:0]      out_hp_q;

  logic [swpg_pkg::SLOW_W-1:0]    slow_lhs;
  logic [swpg_pkg::SLOW_W-1:0]    slow_rhs;
  logic                           slow;
  logic [swpg_pkg::DVD_W-1:0]     dividend;
  logic [swpg_pkg::PROD_W:0]      rem_shift;
  logic [swpg_pkg::PROD_W-1:0]    rem_diff;
  logic                           rem_ge;
  logic [swpg_pkg::HP_W-1:0]      hp_clamped;
  logic [swpg_pkg::HP_W-1:0]      tick_inc;

  // Below 0.05 Hz, without a fix or with a zero product the generator stops.
  assign slow_lhs = swpg_pkg::SLOW_W'(prod_q) * swpg_pkg::SLOW_W'(swpg_pkg::SlowScale);
  assign slow_rhs = swpg_pkg::SLOW_W'({circ_q, 3'b000});
  assign slow     = !fix_q || (prod_q == '0) || (slow_lhs < slow_rhs);
  assign dividend = swpg_pkg::DVD_W'(circ_q) * swpg_pkg::DVD_W'(swpg_pkg::HalfPeriodScale);

  assign rem_shift = {rem_q, quot_q[swpg_pkg::DVD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, prod_q};
  assign rem_diff  = rem_shift[swpg_pkg::PROD_W-1:0] - prod_q;

  always_comb begin
    if (quot_q == '0) begin
      hp_clamped = swpg_pkg::HP_W'(1);
    end else if (|quot_q[swpg_pkg::DVD_W-1:swpg_pkg::HP_W]) begin
      hp_clamped = swpg_pkg::HalfPeriodMax;
    end else begin
      hp_clamped = quot_q[swpg_pkg::HP_W-1:0];
    end
  end

  assign tick_inc = tick_q + swpg_pkg::HP_W'(1);

  assign status_o.is_tick  = in_action_i;
  assign status_o.slow     = slow;
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q <= swpg_pkg::CircReset;
      ppr_q  <= swpg_pkg::PprReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swpg_pkg::REG_CIRC: circ_q <= cfg_data_i;
        swpg_pkg::REG_PPR:  ppr_q  <= cfg_data_i[swpg_pkg::PPR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= 1'b0;
      running_q     <= 1'b0;
      half_period_q <= '0;
      tick_q        <= '0;
    end else if (cmd_i.accept && in_action_i) begin
      if (!running_q) begin
        level_q <= 1'b0;
      end else if (tick_inc >= half_period_q) begin
        level_q <= !level_q;
        tick_q  <= '0;
      end else begin
        tick_q <= tick_inc;
      end
    end else if (cmd_i.check && slow) begin
      level_q       <= 1'b0;
      running_q     <= 1'b0;
      half_period_q <= '0;
      tick_q        <= '0;
    end else if (cmd_i.finish) begin
      running_q     <= 1'b1;
      half_period_q <= hp_clamped;
      tick_q        <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fix_q  <= in_has_fix_i;
      prod_q <= swpg_pkg::PROD_W'(in_speed_q8_i) * swpg_pkg::PROD_W'(ppr_q);
    end
    if (cmd_i.check) begin
      rem_q  <= '0;
      quot_q <= dividend;
      cnt_q  <= swpg_pkg::DivLastBit;
    end else if (cmd_i.step) begin
      rem_q  <= rem_ge ? rem_diff : rem_shift[swpg_pkg::PROD_W-1:0];
      quot_q <= {quot_q[swpg_pkg::DVD_W-2:0], rem_ge};
      cnt_q  <= cnt_q - swpg_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_level_q   <= level_q;
      out_running_q <= running_q;
      out_hp_q      <= running_q ? half_period_q : '0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_pulse_out_o      = out_level_q;
  assign out_pulse_enabled_o  = out_running_q;
  assign out_half_cycle_us_o  = out_hp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !running_q |-> !level_q)
    else $error("Pulse level is high while the generator is stopped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) running_q |-> half_period_q != '0)
    else $error("Generator is running with a zero half period.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) running_q |-> tick_q < half_period_q)
    else $error("Tick count has reached the half period without a toggle.");

endmodule

`default_nettype wire

@@ hdl/speed_to_wheel_pulse_generator.sv @@
// Path: a tick goes from the idle state to the done state and then to the output register;
// a speed update that stops the generator also passes the check state, and one that starts
// it passes check, the 29 steps of the restoring divider and finish. A new item is taken only
// in the idle state, once the last result is in the output register; the divider shares one
// subtractor for all quotient bits. A stalled output holds the block until the result leaves.
// Reset: asynchronous, active low; generator stopped, output valid low, config at defaults.
`timescale 1ns / 1ps
`default_nettype none

module speed_to_wheel_pulse_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  swpg_in_if.sink                              in_i,
  swpg_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [swpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [swpg_pkg::CIRC_W-1:0]     cfg_data_i
);

  swpg_pkg::ctrl_cmd_t  cmd;
  swpg_pkg::dp_status_t status;
  logic                 in_ready;

  swpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swpg_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_action_i          (in_i.action),
    .in_speed_q8_i        (in_i.speed_q8),
    .in_has_fix_i         (in_i.has_fix),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .out_pulse_out_o      (out_o.pulse_out),
    .out_pulse_enabled_o  (out_o.pulse_enabled),
    .out_half_cycle_us_o  (out_o.half_cycle_us)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire
